@@ sv/sope_pkg.sv @@
// shared types and constants for the second-order plant estimator
// no dependencies; used by the estimator top and the bench, not by sope_mul or sope_div
`default_nettype none

package sope_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int PCT_WIDTH    = 7;

	localparam logic [PCT_WIDTH-1:0] PCT_RESET = 7'd10;
	localparam logic [PCT_WIDTH-1:0] PCT_SCALE = 7'd100;

	localparam logic CMD_CTRL = 1'b0;
	localparam logic CMD_MEAS = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_SINGULAR = 1'b1;

	localparam logic signed [SAMPLE_WIDTH-1:0] ENTRY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                           command;
		logic signed [SAMPLE_WIDTH-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] coef_a1;
		logic signed [SAMPLE_WIDTH-1:0] coef_a2;
		logic                           solve_status;
	} out_item_t;

endpackage

`default_nettype wire

@@ sv/sope_mul.sv @@
// registered signed multiplier shared by all products of the 2x2 solve
// no package dependencies
`default_nettype none

module sope_mul #(
	parameter int WIDTH = 32
) (
	input  logic                      clk,
	input  logic signed [WIDTH-1:0]   op_a,
	input  logic signed [WIDTH-1:0]   op_b,
	output logic signed [2*WIDTH-1:0] product
);

	logic signed [2*WIDTH-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign product = prod_s1;

endmodule

`default_nettype wire

@@ sv/sope_div.sv @@
// iterative restoring divider: fixed-point quotient num/den, one bit per cycle
// truncates toward zero, saturates to the signed result range; no package use
`default_nettype none

module sope_div #(
	parameter int WIDTH     = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [2*WIDTH-1:0] num,
	input  logic signed [2*WIDTH-1:0] den,
	output logic                      done,
	output logic signed [WIDTH-1:0]   quotient
);

	localparam int NW = 2 * WIDTH;
	localparam int QB = WIDTH - 1;
	localparam int CW = $clog2(QB + 1);
	localparam int EW = NW + FRAC_BITS;
	localparam logic [CW-1:0] CNT_LAST = CW'(QB - 1);
	localparam logic signed [WIDTH-1:0] Q_MAX = {1'b0, {QB{1'b1}}};
	localparam logic signed [WIDTH-1:0] Q_MIN = {1'b1, {QB{1'b0}}};

	logic [NW-1:0] num_mag;
	logic [NW-1:0] den_mag;
	logic [EW-1:0] num_ext;
	logic [NW-1:0] rem_init;
	logic [NW-1:0] rem_sh;
	logic          rem_ge;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          ovf_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [QB-1:0] low_q;
	logic [QB-1:0] quo_q;

	assign num_mag  = num[NW-1] ? NW'(-num) : NW'(num);
	assign den_mag  = den[NW-1] ? NW'(-den) : NW'(den);
	assign num_ext  = {num_mag, {FRAC_BITS{1'b0}}};
	assign rem_init = NW'(num_ext[EW-1:QB]);
	assign rem_sh   = {rem_q[NW-2:0], low_q[QB-1]};
	assign rem_ge   = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (ovf_q || cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den_mag;
			rem_q <= rem_init;
			low_q <= num_ext[QB-1:0];
			quo_q <= '0;
			neg_q <= num[NW-1] ^ den[NW-1];
			ovf_q <= rem_init >= den_mag;
		end else if (busy_q) begin
			rem_q <= rem_ge ? rem_sh - den_q : rem_sh;
			low_q <= {low_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], rem_ge};
		end
	end

	always_comb begin
		if (ovf_q) begin
			quotient = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			quotient = -$signed({1'b0, quo_q});
		end else begin
			quotient = $signed({1'b0, quo_q});
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

@@ sv/second_order_plant_estimator.sv @@
// second-order plant estimator: histories, change trigger and solve sequencer
// depends on sope_pkg, sope_mul and sope_div
//
// usage:
//   in channel (in_valid/in_ready, in_data): command 0 shifts the control
//   history, command 1 shifts the output history and runs the change test
//   against the stored reference level. a control sample is taken in the idle
//   state and a measured sample passes the check state; neither gives a result
//   unless the measured sample fires. a firing sample forms the 2x2 system, runs
//   six products through one shared multiplier and two quotients through one
//   bit-serial divider, then the result is registered in the out register. a
//   singular system skips the divider and reports the old coefficients with
//   solve_status set.
//   in_ready is high only while the sequencer is idle: one item at a time.
//   out channel (out_valid/out_ready, out_data) is a register; a held result
//   does not block the next input, but a new result waits until the old one
//   has been taken. cfg_wr_en/cfg_wr_data write the percent threshold.
//   reset: threshold 10, control history 1.0, output history and reference
//   level 7.0, both coefficients 1.0, no result pending.
`default_nettype none

module second_order_plant_estimator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [sope_pkg::PCT_WIDTH-1:0]       cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  sope_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output sope_pkg::out_item_t                  out_data
);

	localparam int W      = sope_pkg::SAMPLE_WIDTH;
	localparam int HIST_W = (FRAC_BITS + 4 > W) ? FRAC_BITS + 4 : W;
	localparam int PW     = sope_pkg::PCT_WIDTH;
	localparam int CMP_W  = HIST_W + 1 + PW;

	localparam logic signed [W-1:0]      ONE_FX   = W'(longint'(1) << FRAC_BITS);
	localparam logic signed [HIST_W-1:0] SEVEN_FX = HIST_W'(longint'(7) << FRAC_BITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV1  = 3'd3;
	localparam logic [2:0] ST_DIV2  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam logic [2:0] STEP_LAST = 3'd6;

	function automatic logic signed [W-1:0] clamp_entry(
		input logic signed [HIST_W+1:0] x
	);
		logic signed [HIST_W+1:0] lim;
		lim = (HIST_W+2)'(sope_pkg::ENTRY_MAX);
		if (x > lim) begin
			return sope_pkg::ENTRY_MAX;
		end else if (x < -lim) begin
			return -sope_pkg::ENTRY_MAX;
		end else begin
			return W'(x);
		end
	endfunction

	logic [2:0]               state_q;
	logic [2:0]               step_q;
	logic                     out_valid_q;
	logic [PW-1:0]            pct_q;
	logic signed [W-1:0]      ctrl_hist_q [3];
	logic signed [HIST_W-1:0] out_hist_q  [4];
	logic signed [HIST_W-1:0] level_q;
	logic signed [W-1:0]      coef1_q;
	logic signed [W-1:0]      coef2_q;

	logic signed [W-1:0]      a11_q, a12_q, a21_q, a22_q, c1_q, c2_q;
	logic signed [2*W-1:0]    det_q, n1_q, n2_q;
	logic                     status_q;
	sope_pkg::out_item_t      out_data_q;

	logic                     in_xfer;
	logic signed [HIST_W:0]   d01, d12, d23;
	logic signed [HIST_W+1:0] dd0, dd1, cd0, cd1;
	logic signed [HIST_W:0]   lvl_diff;
	logic signed [HIST_W:0]   y_ext;
	logic [HIST_W:0]          lvl_mag, y_mag;
	logic [CMP_W-1:0]         lhs, rhs;
	logic                     hit;

	logic signed [W-1:0]      op_a, op_b;
	logic signed [2*W-1:0]    product;
	logic                     div_start;
	logic signed [2*W-1:0]    div_num;
	logic                     div_done;
	logic signed [W-1:0]      quotient;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// difference system from the histories
	assign d01 = (HIST_W+1)'(out_hist_q[0]) - (HIST_W+1)'(out_hist_q[1]);
	assign d12 = (HIST_W+1)'(out_hist_q[1]) - (HIST_W+1)'(out_hist_q[2]);
	assign d23 = (HIST_W+1)'(out_hist_q[2]) - (HIST_W+1)'(out_hist_q[3]);
	assign dd0 = (HIST_W+2)'(d01) - (HIST_W+2)'(d12);
	assign dd1 = (HIST_W+2)'(d12) - (HIST_W+2)'(d23);
	assign cd0 = (HIST_W+2)'(ctrl_hist_q[0]) - (HIST_W+2)'(ctrl_hist_q[1]);
	assign cd1 = (HIST_W+2)'(ctrl_hist_q[1]) - (HIST_W+2)'(ctrl_hist_q[2]);

	// change test: |100*(level-y)| >= pct*|y|
	assign y_ext    = (HIST_W+1)'(out_hist_q[0]);
	assign lvl_diff = (HIST_W+1)'(level_q) - y_ext;
	assign lvl_mag  = lvl_diff[HIST_W] ? (HIST_W+1)'(-lvl_diff) : (HIST_W+1)'(lvl_diff);
	assign y_mag    = y_ext[HIST_W] ? (HIST_W+1)'(-y_ext) : (HIST_W+1)'(y_ext);
	assign lhs      = CMP_W'(lvl_mag) * CMP_W'(sope_pkg::PCT_SCALE);
	assign rhs      = CMP_W'(y_mag) * CMP_W'(pct_q);
	assign hit      = lhs >= rhs;

	always_comb begin
		case (step_q)
			3'd0: begin
				op_a = a11_q;
				op_b = a22_q;
			end
			3'd1: begin
				op_a = a12_q;
				op_b = a21_q;
			end
			3'd2: begin
				op_a = c1_q;
				op_b = a22_q;
			end
			3'd3: begin
				op_a = a12_q;
				op_b = c2_q;
			end
			3'd4: begin
				op_a = a11_q;
				op_b = c2_q;
			end
			3'd5: begin
				op_a = a21_q;
				op_b = c1_q;
			end
			default: begin
				op_a = a11_q;
				op_b = a22_q;
			end
		endcase
	end

	assign div_start = ((state_q == ST_MUL) && (step_q == STEP_LAST) && (det_q != '0))
		|| ((state_q == ST_DIV1) && div_done);
	assign div_num   = (state_q == ST_MUL) ? n1_q : n2_q;

	sope_mul #(
		.WIDTH (W)
	) u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (product)
	);

	sope_div #(
		.WIDTH     (W),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (det_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			pct_q       <= sope_pkg::PCT_RESET;
			for (int i = 0; i < 3; i++) ctrl_hist_q[i] <= ONE_FX;
			for (int i = 0; i < 4; i++) out_hist_q[i] <= SEVEN_FX;
			level_q     <= SEVEN_FX;
			coef1_q     <= ONE_FX;
			coef2_q     <= ONE_FX;
		end else begin
			if (cfg_wr_en) begin
				pct_q <= cfg_wr_data;
			end
			if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.command == sope_pkg::CMD_CTRL) begin
							ctrl_hist_q[2] <= ctrl_hist_q[1];
							ctrl_hist_q[1] <= ctrl_hist_q[0];
							ctrl_hist_q[0] <= in_data.sample_value;
						end else begin
							out_hist_q[3] <= out_hist_q[2];
							out_hist_q[2] <= out_hist_q[1];
							out_hist_q[1] <= out_hist_q[0];
							out_hist_q[0] <= HIST_W'(in_data.sample_value);
							state_q       <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (hit) begin
						level_q <= out_hist_q[0];
						step_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_LAST) begin
						state_q <= (det_q == '0) ? ST_FIN : ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						coef1_q <= quotient;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						coef2_q <= quotient;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			a11_q <= clamp_entry((HIST_W+2)'(d01));
			a12_q <= clamp_entry(dd0);
			a21_q <= clamp_entry((HIST_W+2)'(d12));
			a22_q <= clamp_entry(dd1);
			c1_q  <= clamp_entry(cd0);
			c2_q  <= clamp_entry(cd1);
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				3'd1:    det_q <= product;
				3'd2:    det_q <= det_q - product;
				3'd3:    n1_q  <= product;
				3'd4:    n1_q  <= n1_q - product;
				3'd5:    n2_q  <= product;
				3'd6:    n2_q  <= n2_q - product;
				default: det_q <= det_q;
			endcase
			if (step_q == STEP_LAST) begin
				status_q <= (det_q == '0) ? sope_pkg::STATUS_SINGULAR : sope_pkg::STATUS_OK;
			end
		end
		if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
			out_data_q.coef_a1      <= coef1_q;
			out_data_q.coef_a2      <= coef2_q;
			out_data_q.solve_status <= status_q;
		end
	end

endmodule

`default_nettype wire

@@ bench/sope_estimate_checker.sv @@
`timescale 1ns / 1ps
// checker for the second-order plant estimator: watches the input, output and
// register write ports, predicts every estimate and compares it field by field
// depends on sope_pkg
module sope_estimate_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sope_pkg::PCT_WIDTH-1:0] cfg_wr_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  sope_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  sope_pkg::out_item_t            out_data,
	output int                             fail_count,
	output int                             pending,
	output int                             checked_count,
	output int                             singular_count
);
	import sope_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam longint ONE_FX = longint'(1) << FRAC_BITS;
	localparam longint ENTRY_LIM = longint'(ENTRY_MAX);
	localparam bit [63:0] QUOT_INT_LIMIT = 64'd1 << (SW - 1 - FRAC_BITS);
	localparam bit [63:0] COEF_POS_LIMIT = (64'd1 << (SW - 1)) - 64'd1;
	localparam logic signed [SW-1:0] COEF_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] COEF_MIN = {1'b1, {(SW-1){1'b0}}};

	logic [PCT_WIDTH-1:0] thresh_pct;
	longint ctrl_hist [3];
	longint meas_hist [4];
	longint ref_level;
	logic signed [SW-1:0] coef1, coef2;
	out_item_t expected_estimates [$];
	out_item_t predicted, want;

	function automatic bit [63:0] abs_u64(input longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint limit_entry(input longint x);
		if (x > ENTRY_LIM)
			return ENTRY_LIM;
		if (x < -ENTRY_LIM)
			return -ENTRY_LIM;
		return x;
	endfunction

	// fixed-point quotient, truncated toward zero, saturated to the coefficient range
	function automatic logic signed [SW-1:0] fx_quotient(input longint num, input longint den);
		bit neg;
		bit [63:0] un, ud, v;
		bit [64:0] rem;
		logic signed [SW-1:0] coef;
		int i;
		neg = (num < 0) != (den < 0);
		un = abs_u64(num);
		ud = abs_u64(den);
		v = un / ud;
		rem = 65'(un % ud);
		if (v >= QUOT_INT_LIMIT)
			return neg ? COEF_MIN : COEF_MAX;
		for (i = 0; i < FRAC_BITS; i++) begin
			rem = rem << 1;
			v = v << 1;
			if (rem >= {1'b0, ud}) begin
				rem = rem - {1'b0, ud};
				v[0] = 1'b1;
			end
		end
		if (v > COEF_POS_LIMIT)
			return neg ? COEF_MIN : COEF_MAX;
		coef = v[SW-1:0];
		return neg ? -coef : coef;
	endfunction

	// updates the histories and returns 1 when the sample triggers a new estimate
	function automatic bit estimate_step(input in_item_t item, output out_item_t est);
		longint y, d01, d12, d23, a11, a12, a21, a22, c1, c2, det;
		bit [63:0] lhs, rhs;
		y = longint'(item.sample_value);
		est = '0;
		if (item.command == CMD_CTRL) begin
			ctrl_hist[2] = ctrl_hist[1];
			ctrl_hist[1] = ctrl_hist[0];
			ctrl_hist[0] = y;
			return 1'b0;
		end
		meas_hist[3] = meas_hist[2];
		meas_hist[2] = meas_hist[1];
		meas_hist[1] = meas_hist[0];
		meas_hist[0] = y;
		lhs = abs_u64(ref_level - y) * 64'd100;
		rhs = abs_u64(y) * 64'(thresh_pct);
		if (lhs < rhs)
			return 1'b0;
		d01 = meas_hist[0] - meas_hist[1];
		d12 = meas_hist[1] - meas_hist[2];
		d23 = meas_hist[2] - meas_hist[3];
		a11 = limit_entry(d01);
		a12 = limit_entry(d01 - d12);
		a21 = limit_entry(d12);
		a22 = limit_entry(d12 - d23);
		c1 = limit_entry(ctrl_hist[0] - ctrl_hist[1]);
		c2 = limit_entry(ctrl_hist[1] - ctrl_hist[2]);
		det = a11 * a22 - a12 * a21;
		if (det != 0) begin
			coef1 = fx_quotient(c1 * a22 - a12 * c2, det);
			coef2 = fx_quotient(a11 * c2 - a21 * c1, det);
		end
		ref_level = y;
		est.coef_a1 = coef1;
		est.coef_a2 = coef2;
		est.solve_status = (det == 0) ? STATUS_SINGULAR : STATUS_OK;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_pct = PCT_RESET;
			foreach (ctrl_hist[i])
				ctrl_hist[i] = ONE_FX;
			foreach (meas_hist[i])
				meas_hist[i] = 7 * ONE_FX;
			ref_level = 7 * ONE_FX;
			coef1 = ONE_FX[SW-1:0];
			coef2 = ONE_FX[SW-1:0];
			expected_estimates.delete();
			fail_count = 0;
			pending = 0;
			checked_count = 0;
			singular_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_estimates.size() == 0) begin
					$display("%0t: unexpected estimate transfer, a1 %h a2 %h status %b",
						$time, out_data.coef_a1, out_data.coef_a2, out_data.solve_status);
					fail_count++;
				end else begin
					want = expected_estimates.pop_front();
					checked_count++;
					if (want.solve_status == STATUS_SINGULAR)
						singular_count++;
					if (out_data.coef_a1 !== want.coef_a1) begin
						$display("%0t: coef_a1 expected %h actual %h",
							$time, want.coef_a1, out_data.coef_a1);
						fail_count++;
					end
					if (out_data.coef_a2 !== want.coef_a2) begin
						$display("%0t: coef_a2 expected %h actual %h",
							$time, want.coef_a2, out_data.coef_a2);
						fail_count++;
					end
					if (out_data.solve_status !== want.solve_status) begin
						$display("%0t: solve_status expected %b actual %b",
							$time, want.solve_status, out_data.solve_status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready && estimate_step(in_data, predicted))
				expected_estimates.push_back(predicted);
			if (cfg_wr_en)
				thresh_pct = cfg_wr_data;
			pending = expected_estimates.size();
		end
	end

endmodule

@@ bench/tb_second_order_plant_estimator.sv @@
`timescale 1ns / 1ps
// testbench top for the second-order plant estimator: clock, reset, directed and
// random samples, threshold writes, flow control and the verdict
// depends on sope_pkg, second_order_plant_estimator and sope_estimate_checker
module tb_second_order_plant_estimator;
	import sope_pkg::*;

	localparam int QUIET_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int ITEMS_PER_SETTING = 105;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [PCT_WIDTH-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	int fail_count, pending, checked_count, singular_count;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int meas_sent = 0;
	int settings_used = 0;
	logic signed [31:0] last_meas = 32'sh0007_0000;
	int ramp_left = 0;
	int ramp_step = 0;

	second_order_plant_estimator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	sope_estimate_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.checked_count(checked_count),
		.singular_count(singular_count)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// result side flow control, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_cnt = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			out_ready <= 1'b0;
			hold_cnt = hold_cnt - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_item(input logic cmd, input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= in_item_t'{command: cmd, sample_value: val};
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (cmd == CMD_MEAS) begin
			meas_sent++;
			last_meas = val;
		end
		@(negedge clk);
	endtask

	// drop valid, let every estimate drain, then give the block time to go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_threshold(input int pct);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= PCT_WIDTH'(pct);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random_sample();
		int pick, k;
		longint scaled;
		logic [31:0] small_val;
		pick = $urandom_range(99);
		small_val = 32'(int'($urandom_range(1 << 20)) - (1 << 19));
		if (ramp_left == 0 && pick >= 88 && pick < 94) begin
			ramp_left = 4;
			ramp_step = int'($urandom_range(1 << 18)) - (1 << 17);
		end
		if (ramp_left > 0) begin
			ramp_left--;
			send_item(CMD_MEAS, 32'(longint'(last_meas) + ramp_step));
		end else if (pick < 30)
			send_item(CMD_CTRL, $urandom_range(1) ? $urandom : small_val);
		else if (pick < 45)
			send_item(CMD_MEAS, $urandom);
		else if (pick < 70)
			send_item(CMD_MEAS, small_val);
		else if (pick < 94) begin
			// close to the last measured value, around the trigger boundary
			k = int'($urandom_range(400)) - 200;
			scaled = longint'(last_meas) + (longint'(last_meas) * k) / 1000;
			send_item(CMD_MEAS, 32'(scaled));
		end else if (pick < 97)
			send_item(CMD_MEAS, 32'h0000_0000);
		else
			case ($urandom_range(3))
				0: send_item(1'($urandom), 32'h7fff_ffff);
				1: send_item(1'($urandom), 32'h8000_0000);
				2: send_item(1'($urandom), 32'h0000_0001);
				default: send_item(1'($urandom), 32'hffff_ffff);
			endcase
	endtask

	initial begin
		int phase, sub, n, pct;
		int pct_plan [9];
		pct_plan = '{1, 100, -1, 50, 10, -1, 99, 2, -1};
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset threshold: extremes, zero samples, ramps and no-trigger cases
		send_item(CMD_MEAS, 32'h0000_0000);
		send_item(CMD_MEAS, 32'h7fff_ffff);
		send_item(CMD_MEAS, 32'h8000_0000);
		send_item(CMD_CTRL, 32'h8000_0000);
		send_item(CMD_CTRL, 32'h7fff_ffff);
		send_item(CMD_MEAS, 32'h0001_0000);
		repeat (4)
			send_item(CMD_MEAS, 32'h0000_0000);
		send_item(CMD_MEAS, 32'h0001_0000);
		send_item(CMD_MEAS, 32'h0002_0000);
		send_item(CMD_MEAS, 32'h0003_0000);
		send_item(CMD_MEAS, 32'h0004_0000);
		send_item(CMD_CTRL, 32'h0000_0000);
		send_item(CMD_CTRL, 32'h0001_0000);
		send_item(CMD_MEAS, 32'hfffc_8000);
		send_item(CMD_MEAS, 32'h0005_4000);
		send_item(CMD_MEAS, 32'hffff_0000);
		send_item(CMD_MEAS, 32'hffff_0000);
		send_item(CMD_MEAS, 32'hfffe_e333);
		send_item(CMD_CTRL, 32'hffff_ffff);

		write_threshold(0);
		send_item(CMD_MEAS, 32'h0007_0000);
		send_item(CMD_MEAS, 32'h0007_0000);
		send_item(CMD_CTRL, 32'h0002_0000);
		send_item(CMD_MEAS, 32'h0003_0000);
		write_threshold(127);
		send_item(CMD_MEAS, 32'h0003_0000);
		send_item(CMD_MEAS, 32'h0006_0000);
		send_item(CMD_MEAS, 32'hff9c_0000);
		send_item(CMD_MEAS, 32'h0001_0000);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 21;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (sub = 0; sub < 3; sub++) begin
				pct = pct_plan[phase * 3 + sub];
				if (pct < 0)
					pct = $urandom_range(1, 100);
				write_threshold(pct);
				for (n = 0; n < ITEMS_PER_SETTING; n++) begin
					if (phase == 2 && sub == 0 && n == 20)
						hold_req = 1'b1;
					if (phase == 2 && sub == 0 && n == 60)
						settle();
					send_random_sample();
				end
			end
		end

		settle();
		$display("run covered %0d samples (%0d measured) over %0d threshold writes",
			items_sent, meas_sent, settings_used);
		$display("%0d estimates compared, %0d from singular systems",
			checked_count, singular_count);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
